// ===== rtl/ptt_pkg.sv =====
// Shared constants, codes and types for the periodic timer table.
// No dependencies; imported by every module of the block.
package ptt_pkg;

  localparam int TIMERS  = 32;                      // table depth
  localparam int IDX_W   = $clog2(TIMERS);          // entry address width
  localparam int CNT_W   = $clog2(TIMERS + 1);      // fill count width
  localparam int CMP_W   = ((CNT_W > 5) ? CNT_W : 5) + 1;
  localparam int OUTC_W  = (CNT_W > 6) ? CNT_W : 6;
  localparam int VAL_W   = 20;                      // period / elapsed width
  localparam int MASK_W  = 32;                      // fired mask width

  localparam logic [9:0] TPM_RESET = 10'd60;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] elapsed;
  } entry_t;

endpackage

// ===== rtl/ptt_entry_update.sv =====
// One tick applied to one table entry: advance, wrap and fire; a zero period holds it.
// Depends on ptt_pkg (entry_t).
module ptt_entry_update
  import ptt_pkg::*;
(
  input  entry_t cur,
  output entry_t nxt,
  output logic   fired
);

  logic [VAL_W-1:0] inc;

  assign inc = cur.elapsed + 1'b1;   // wraps at 20 bits

  always_comb begin
    nxt   = cur;
    fired = 1'b0;
    if (cur.period != '0) begin
      if (inc >= cur.period) begin
        nxt.elapsed = '0;
        fired       = 1'b1;
      end else begin
        nxt.elapsed = inc;
      end
    end
  end

endmodule

// ===== rtl/periodic_timer_table.sv =====
// Top level of the periodic timer table: handshakes, sequencer and entry memory.
// Depends on ptt_pkg and ptt_entry_update.
//
//  channel | direction | ports                                        | transfer
//  --------+-----------+----------------------------------------------+---------------------
//  in      | input     | in_op, in_period_minutes, in_entry_index     | in_valid & in_ready
//  out     | output    | out_fired_mask, out_entry_count, out_status  | out_valid & out_ready
//  cfg     | input     | cfg_wdata (ticks_per_minute)                 | cfg_we
//
// Add, rejected items, op 3 and a remove of the last entry go from idle straight to
// done; a tick walks every live entry, a remove at index k shifts the entries above k
// down one place. The walk uses one read port and one write port, one entry a cycle.
// One item is in work at a time; in_ready is high only when idle.
// Reset (synchronous, rst_n low) empties the table and sets ticks_per_minute to 60;
// the memory itself is not cleared, entries at or above the count are never read.
// A result that is not taken holds the sequencer in its done state.
module periodic_timer_table
  import ptt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [9:0]        in_period_minutes,
  input  logic [4:0]        in_entry_index,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_fired_mask,
  output logic [5:0]        out_entry_count,
  output logic [1:0]        out_status,
  // configuration
  input  logic              cfg_we,
  input  logic [9:0]        cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_t            state_r,     state_nxt;
  logic              is_tick_r,   is_tick_nxt;   // walk kind: tick or remove
  logic [CNT_W-1:0]  used_r,      used_nxt;
  logic [CNT_W-1:0]  rd_ptr_r,    rd_ptr_nxt;    // next entry to read
  logic              rd_vld_r,    rd_vld_nxt;    // rd_data_r holds a walked entry
  logic [IDX_W-1:0]  rd_addr_r;                  // address behind rd_data_r
  entry_t            rd_data_r;
  logic [MASK_W-1:0] mask_r,      mask_nxt;
  logic [1:0]        status_r,    status_nxt;
  logic [9:0]        tpm_r;
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r;
  logic [5:0]        out_count_r;
  logic [1:0]        out_status_r;

  // memory ports
  entry_t            mem [TIMERS];
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  // datapath
  entry_t            upd_entry;
  logic              upd_fired;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  used_ext;
  logic [CMP_W-1:0]  idx_plus1;
  logic [2*10-1:0]   product;
  logic [OUTC_W-1:0] count_ext;
  logic              accept;
  logic              out_free;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_ext   = CMP_W'(in_entry_index);
  assign used_ext  = CMP_W'(used_r);
  assign idx_plus1 = idx_ext + 1'b1;
  assign product   = {10'd0, in_period_minutes} * {10'd0, tpm_r};   // always fits in 20 bits
  assign count_ext = OUTC_W'(used_r);

  ptt_entry_update u_update (
    .cur   (rd_data_r),
    .nxt   (upd_entry),
    .fired (upd_fired)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    is_tick_nxt   = is_tick_r;
    used_nxt      = used_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_vld_nxt    = 1'b0;
    mask_nxt      = mask_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_addr       = IDX_W'(rd_ptr_r);
    wr_en         = 1'b0;
    wr_addr       = rd_addr_r;
    wr_data       = upd_entry;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mask_nxt   = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_op)
            OP_TICK: begin
              is_tick_nxt = 1'b1;
              rd_ptr_nxt  = '0;
              if (used_r != '0) state_nxt = S_WALK;
            end
            OP_ADD: begin
              if (used_ext >= CMP_W'(TIMERS)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en           = 1'b1;
                wr_addr         = IDX_W'(used_r);
                wr_data.period  = product[VAL_W-1:0];
                wr_data.elapsed = '0;
                used_nxt        = used_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              is_tick_nxt = 1'b0;
              if (idx_ext >= used_ext) begin
                status_nxt = ST_BADIDX;
              end else if (idx_plus1 >= used_ext) begin
                used_nxt = used_r - 1'b1;   // last entry: nothing to shift
              end else begin
                rd_ptr_nxt = CNT_W'(idx_plus1);
                state_nxt  = S_WALK;
              end
            end
            default: ;   // unused op: no change, ok status
          endcase
        end
      end

      S_WALK: begin
        // issue the next read
        if (rd_ptr_r < used_r) begin
          rd_en      = 1'b1;
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        // write back the entry read last cycle
        if (rd_vld_r) begin
          wr_en = 1'b1;
          if (is_tick_r) begin
            wr_addr = rd_addr_r;
            wr_data = upd_entry;
            if (upd_fired && (rd_addr_r < MASK_W))
              mask_nxt = mask_r | (MASK_W'(1) << rd_addr_r);
          end else begin
            wr_addr = rd_addr_r - 1'b1;   // shift down by one place
            wr_data = rd_data_r;
          end
          if (rd_ptr_r >= used_r) begin
            state_nxt = S_DONE;
            if (!is_tick_r) used_nxt = used_r - 1'b1;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tpm_r       <= TPM_RESET;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) tpm_r <= cfg_wdata;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    is_tick_r <= is_tick_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    mask_r    <= mask_nxt;
    status_r  <= status_nxt;
    if (state_r == S_DONE && out_free) begin
      out_mask_r   <= mask_r;
      out_count_r  <= count_ext[5:0];
      out_status_r <= status_r;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_fired_mask  = out_mask_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

`ifndef SYNTH
  // fill count never exceeds the table
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TIMERS))
    else $error("entry count above table depth");

  // walk writes only touch live entries
  a_walk_wr_live: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_WALK) |-> (CNT_W'(wr_addr) < used_r))
    else $error("walk write outside live entries");

  // an accepted add on a non-full table grows the count by one
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_ADD && used_r < CNT_W'(TIMERS))
      |=> (used_r == $past(used_r) + 1'b1))
    else $error("add did not grow the table");
`endif

endmodule

// ===== tb/periodic_timer_table_tb.sv =====
// Testbench for periodic_timer_table: directed and random tick/add/remove traffic.
// The expected results come from a behavioral copy of the timer table inside this file.
// Depends on ptt_pkg and the periodic_timer_table RTL only.
module periodic_timer_table_tb
  import ptt_pkg::*;
();

  // op 3 has no package name; the block treats it as a no-op
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int LONG_HOLD     = 300;      // receiver hold-off used to back up the block
  localparam int TAIL_CYCLES   = TIMERS + 8; // longest walk (tick) plus margin
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TIMEOUT_CYCLES = 1000000;

  typedef struct packed {
    logic [MASK_W-1:0] fired;
    logic [5:0]        count;
    logic [1:0]        status;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_op;
  logic [9:0]        in_period_minutes;
  logic [4:0]        in_entry_index;
  logic              out_valid;
  logic              out_ready;
  logic [MASK_W-1:0] out_fired_mask;
  logic [5:0]        out_entry_count;
  logic [1:0]        out_status;
  logic              cfg_we;
  logic [9:0]        cfg_wdata;

  // Shadow of the timer table, updated when an item transfer happens
  logic [VAL_W-1:0] table_period  [TIMERS];
  logic [VAL_W-1:0] table_elapsed [TIMERS];
  int               table_used;
  logic [9:0]       scale_tpm;

  result_t awaited_results[$];
  int      fail_count = 0;

  // Traffic shaping shared by sender and receiver
  bit steady        = 1'b0;  // no gaps on either side while set
  bit long_hold_req = 1'b0;  // ask the receiver for one long hold-off

  periodic_timer_table i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_period_minutes (in_period_minutes),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fired_mask    (out_fired_mask),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  // Small periods so that timers actually fire; full range now and then
  function automatic logic [9:0] pick_minutes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 10'd0;
    if (r < 75) return 10'($urandom_range(1, 4));
    if (r < 92) return 10'($urandom_range(0, 1023));
    return 10'h3FF;
  endfunction

  // Mostly a live entry, sometimes any index (bad index when above the fill)
  function automatic logic [4:0] pick_index();
    if (table_used > 0 && $urandom_range(0, 9) < 8)
      return 5'($urandom_range(0, table_used - 1));
    return 5'($urandom_range(0, 31));
  endfunction

  // Apply one item to the shadow table and return the result the block must give.
  function automatic result_t apply_item(input logic [1:0] op, input logic [9:0] minutes,
                                         input logic [4:0] idx);
    result_t          r;
    logic [VAL_W-1:0] e;
    r = '0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < table_used; i++) begin
          // zero period: never fires, count frozen
          if (table_period[i] != '0) begin
            e = table_elapsed[i] + 1'b1;
            if (e >= table_period[i]) begin
              e = '0;
              if (i < MASK_W) r.fired[i] = 1'b1;
            end
            table_elapsed[i] = e;
          end
        end
      end
      OP_ADD: begin
        if (table_used >= TIMERS) begin
          r.status = ST_FULL;
        end else begin
          // product fits in 20 bits for any 10-bit operands
          table_period[table_used]  = {10'd0, minutes} * {10'd0, scale_tpm};
          table_elapsed[table_used] = '0;
          table_used++;
        end
      end
      OP_REMOVE: begin
        if (int'(idx) >= table_used) begin
          r.status = ST_BADIDX;
        end else begin
          // compact: everything above the hole moves down one slot
          for (int i = int'(idx); i < table_used - 1; i++) begin
            table_period[i]  = table_period[i + 1];
            table_elapsed[i] = table_elapsed[i + 1];
          end
          table_used--;
        end
      end
      default: ;  // ignored op: empty mask, status ok
    endcase
    r.count = 6'(table_used);
    return r;
  endfunction

  // Offer one item; valid stays up across back-to-back items with no gap.
  // The expectation is queued at the edge where the transfer happens.
  task automatic send_item(input logic [1:0] op, input logic [9:0] minutes,
                           input logic [4:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_period_minutes <= minutes;
    in_entry_index    <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    awaited_results.push_back(apply_item(op, minutes, idx));
  endtask

  // Stop offering and wait until every result has been taken.
  // Always advances at least one edge so valid never gets two updates in one step.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Register write only with the block idle; every item yields a result,
  // so an empty queue means nothing is in flight.
  task automatic write_tpm(input logic [9:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scale_tpm = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] gotv);
    if (gotv !== expv) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, gotv);
    end
  endtask

  // Result checker: sample pre-edge values at each transfer on the out channel
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual mask %h count %0d status %0d",
                 $time, out_fired_mask, out_entry_count, out_status);
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("fired_mask", 32'(exp_r.fired), 32'(out_fired_mask));
        check_field("entry_count", 32'(exp_r.count), 32'(out_entry_count));
        check_field("status", 32'(exp_r.status), 32'(out_status));
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while steady
  initial begin
    int hold_left;
    int stall;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        stall = pick_gap();
        hold_left = (stall > 0) ? stall - 1 : 0;
        out_ready <= (stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Empty table: tick, bad remove, ignored op; then adds of zero and maximum minutes, tick, removes
  task automatic test_empty_table();
    send_item(OP_TICK, 10'd0, 5'd0);
    send_item(OP_REMOVE, 10'd0, 5'd0);
    send_item(OP_IGNORED, 10'h3FF, 5'h1F);
    send_item(OP_ADD, 10'd0, 5'd0);
    send_item(OP_ADD, 10'h3FF, 5'd0);
    send_item(OP_TICK, 10'h3FF, 5'h1F);
    send_item(OP_REMOVE, 10'd0, 5'h1F);
    send_item(OP_REMOVE, 10'd0, 5'd0);
  endtask

  // Largest scale times largest minutes: the widest period there is
  task automatic test_max_period();
    write_tpm(10'h3FF);
    send_item(OP_ADD, 10'h3FF, 5'd0);
    send_item(OP_ADD, 10'd1, 5'd0);
    send_item(OP_TICK, 10'd0, 5'd0);
    send_item(OP_REMOVE, 10'd0, 5'd0);
    send_item(OP_REMOVE, 10'd0, 5'd0);
  endtask

  // Zero scale gives zero-period timers, which must never fire
  task automatic test_zero_scale();
    write_tpm(10'd0);
    send_item(OP_ADD, 10'd5, 5'd0);
    send_item(OP_TICK, 10'd0, 5'd0);
    send_item(OP_TICK, 10'd0, 5'd0);
  endtask

  // Scale of one: periods of one and two ticks fire on the next ticks
  task automatic test_fast_fire();
    write_tpm(10'd1);
    send_item(OP_ADD, 10'd1, 5'd0);
    send_item(OP_ADD, 10'd2, 5'd0);
    send_item(OP_TICK, 10'd0, 5'd0);
    send_item(OP_TICK, 10'd0, 5'd0);
    send_item(OP_TICK, 10'd0, 5'd0);
    send_item(OP_REMOVE, 10'd0, 5'd0);
    send_item(OP_TICK, 10'd0, 5'd0);
  endtask

  // Long receiver hold-off while the sender keeps offering: the block fills with one result
  // on the output and one held in the done state, and must drop in_ready until the hold ends
  task automatic test_backpressure();
    drain_results();
    long_hold_req = 1'b1;
    steady = 1'b1;
    repeat (12) send_item(($urandom_range(0, 1) == 0) ? OP_TICK : OP_ADD,
                          pick_minutes(), pick_index());
    steady = 1'b0;
    drain_results();
  endtask

  // Random traffic at one scale; the add/remove mix steers the fill level
  task automatic test_random_mix(input int items, input logic [9:0] tpm, input int add_pct,
                                 input int rem_pct, input bit no_idle);
    int         r;
    logic [1:0] op;
    write_tpm(tpm);
    steady = no_idle;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < 3)                          op = OP_IGNORED;
      else if (r < 3 + add_pct)           op = OP_ADD;
      else if (r < 3 + add_pct + rem_pct) op = OP_REMOVE;
      else                                op = OP_TICK;
      send_item(op, pick_minutes(), pick_index());
    end
    steady = 1'b0;
  endtask

  initial begin
    int waited;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_op             <= OP_TICK;
    in_period_minutes <= 10'd0;
    in_entry_index    <= 5'd0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 10'd0;
    table_used = 0;
    scale_tpm  = TPM_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_max_period();
    test_zero_scale();
    test_fast_fire();
    test_backpressure();
    test_random_mix(300, 10'd1, 35, 10, 1'b0);     // fills up, hits table full
    test_random_mix(300, 10'd2, 25, 25, 1'b0);
    test_random_mix(200, 10'd1, 30, 20, 1'b1);     // back-to-back transfers
    test_random_mix(150, 10'h3FF, 30, 20, 1'b0);
    test_random_mix(100, 10'd0, 30, 20, 1'b0);
    test_random_mix(300, 10'd3, 12, 35, 1'b0);     // drains toward empty
    test_random_mix(150, TPM_RESET, 30, 20, 1'b0);

    // wind down: wait for the last results, then watch for strays
    in_valid <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      fail_count += awaited_results.size();
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, awaited_results.size());
    end
    if (fail_count == 0)
      $display("periodic_timer_table verification clean");
    else
      $display("periodic_timer_table verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * TIMEOUT_CYCLES);
    $display("%0t: timeout", $time);
    $display("periodic_timer_table verification failed");
    $finish;
  end

endmodule
